[hw/rtl/kreyv_pkg.sv]
// Shared types, constants and round functions for the Kreyvium stream cipher.
// No dependencies; every other file in hw/rtl but kreyv_checker imports this package.
package kreyv_pkg;

   localparam int STATE_BITS            = 288;
   localparam int KEY_BITS              = 128;
   localparam int IV_BITS               = 128;
   localparam int KEY_LOAD_BITS         = 93;
   localparam int ROUNDS_PER_CYCLE      = 8;
   localparam int WARMUP_ROUNDS_DEFAULT = 1152;
   localparam int QUEUE_DEPTH           = 2;
   localparam int BYTE_BITS             = 8;
   localparam int COUNT_BITS            = 4;

   localparam logic [63:0] KEY_RESET = 64'h0;
   localparam logic [63:0] IV_RESET  = 64'h1111_1111_1111_1111;

   // Tap positions of the cipher state.
   localparam int TAP_A_OUT = 65;
   localparam int TAP_A_END = 92;
   localparam int TAP_A_AND = 90;
   localparam int TAP_A_FB  = 170;
   localparam int TAP_B_OUT = 161;
   localparam int TAP_B_END = 176;
   localparam int TAP_B_AND = 174;
   localparam int TAP_B_FB  = 263;
   localparam int TAP_C_OUT = 242;
   localparam int TAP_C_END = 287;
   localparam int TAP_C_AND = 285;
   localparam int TAP_C_FB  = 68;
   localparam int HEAD_B    = 93;
   localparam int HEAD_C    = 177;

   localparam logic ACTION_RESTART = 1'b0;
   localparam logic ACTION_DATA    = 1'b1;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1,
      CSR_IV_HIGH  = 2'd2,
      CSR_IV_LOW   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STATE_BITS-1:0] s;
      logic [KEY_BITS-1:0]   k;
      logic [IV_BITS-1:0]    v;
   } cstate_type;

   // One classified item as it waits between the front and the back end.
   typedef struct packed {
      logic                  restart;
      logic [BYTE_BITS-1:0]  data;
      logic [COUNT_BITS-1:0] nbits;
   } item_type;

   function automatic logic kreyv_zbit(input cstate_type st);
      kreyv_zbit = st.s[TAP_A_OUT] ^ st.s[TAP_A_END] ^ st.s[TAP_B_OUT] ^ st.s[TAP_B_END]
                 ^ st.s[TAP_C_OUT] ^ st.s[TAP_C_END] ^ st.k[KEY_BITS-1];
   endfunction

   function automatic cstate_type kreyv_round(input cstate_type st);
      logic       t1;
      logic       t2;
      logic       t3;
      cstate_type nx;
      t1 = st.s[TAP_A_OUT] ^ st.s[TAP_A_END] ^ (st.s[TAP_A_AND] & st.s[TAP_A_AND+1])
         ^ st.s[TAP_A_FB] ^ st.v[IV_BITS-1];
      t2 = st.s[TAP_B_OUT] ^ st.s[TAP_B_END] ^ (st.s[TAP_B_AND] & st.s[TAP_B_AND+1])
         ^ st.s[TAP_B_FB];
      t3 = st.s[TAP_C_OUT] ^ st.s[TAP_C_END] ^ st.k[KEY_BITS-1]
         ^ (st.s[TAP_C_AND] & st.s[TAP_C_AND+1]) ^ st.s[TAP_C_FB];
      nx.s         = {st.s[STATE_BITS-2:0], t3};
      nx.s[HEAD_B] = t1;
      nx.s[HEAD_C] = t2;
      // The key and IV registers only rotate.
      nx.k = {st.k[KEY_BITS-2:0], st.k[KEY_BITS-1]};
      nx.v = {st.v[IV_BITS-2:0], st.v[IV_BITS-1]};
      kreyv_round = nx;
   endfunction

   // Key bit i sits at key[KEY_BITS-1-i]; the same holds for the IV.
   function automatic cstate_type kreyv_load(input logic [KEY_BITS-1:0] key,
                                             input logic [IV_BITS-1:0]  iv);
      cstate_type st;
      st.s = '0;
      for (int i = 0; i < KEY_LOAD_BITS; i++) begin
         st.s[i] = key[KEY_BITS-1-i];
      end
      for (int i = 0; i < IV_BITS; i++) begin
         st.s[KEY_LOAD_BITS+i] = iv[IV_BITS-1-i];
      end
      for (int i = KEY_LOAD_BITS + IV_BITS; i < STATE_BITS - 1; i++) begin
         st.s[i] = 1'b1;
      end
      st.k = key;
      st.v = iv;
      kreyv_load = st;
   endfunction

endpackage

[hw/rtl/kreyv_front.sv]
// Front end: accepts request transactions, classifies them and queues them.
// Depends on kreyv_pkg.
module kreyv_front import kreyv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type         queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   item_type         incoming;
   logic [COUNT_BITS-1:0] raw_bits;

   assign req_tready = (count_ff != CW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   // Counts above a full byte are clamped here, so the back end never sees them.
   always_comb begin
      raw_bits         = req_tdata[BYTE_BITS +: COUNT_BITS];
      incoming.restart = (req_tuser == ACTION_RESTART);
      incoming.data    = req_tdata[BYTE_BITS-1:0];
      incoming.nbits   = (raw_bits > COUNT_BITS'(ROUNDS_PER_CYCLE)) ?
                         COUNT_BITS'(ROUNDS_PER_CYCLE) : raw_bits;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

[hw/rtl/kreyv_core.sv]
// Back end: the cipher state with eight unrolled rounds per cycle, warm-up
// counter and the registered response stage. Depends on kreyv_pkg.
module kreyv_core import kreyv_pkg::*; #(
   parameter int WARMUP_ROUNDS = WARMUP_ROUNDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  item_type             item,
   output logic                 item_pop,
   input  logic [KEY_BITS-1:0]  key,
   input  logic [IV_BITS-1:0]   iv,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata
);

   localparam int CW_RAW = $clog2(WARMUP_ROUNDS + 1);
   localparam int CW     = (CW_RAW < COUNT_BITS) ? COUNT_BITS : CW_RAW;

   cstate_type            st_ff, st_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]  rsp_data_ff, rsp_data_in;
   cstate_type            stage [ROUNDS_PER_CYCLE+1];
   logic [ROUNDS_PER_CYCLE-1:0] z;
   logic                  warm;
   logic [COUNT_BITS-1:0] step;
   logic [COUNT_BITS-1:0] sel;
   logic [BYTE_BITS-1:0]  mixed;

   assign warm = (rem_ff != '0);
   assign step = (rem_ff >= CW'(ROUNDS_PER_CYCLE)) ?
                 COUNT_BITS'(ROUNDS_PER_CYCLE) : rem_ff[COUNT_BITS-1:0];
   assign sel  = warm ? step : item.nbits;

   // A restart leaves the output stage alone; a data item needs room there.
   assign item_pop = item_valid && !warm &&
                     (item.restart || !rsp_valid_ff || rsp_tready);

   always_comb begin
      stage[0] = st_ff;
      for (int j = 0; j < ROUNDS_PER_CYCLE; j++) begin
         z[j]       = kreyv_zbit(stage[j]);
         stage[j+1] = kreyv_round(stage[j]);
      end
   end

   always_comb begin
      mixed = item.data;
      for (int j = 0; j < ROUNDS_PER_CYCLE; j++) begin
         if (COUNT_BITS'(j) < item.nbits) begin
            mixed[BYTE_BITS-1-j] = item.data[BYTE_BITS-1-j] ^ z[j];
         end
      end
   end

   always_comb begin
      st_in        = st_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (warm) begin
         st_in  = stage[sel];
         rem_in = rem_ff - CW'(step);
      end else if (item_pop && item.restart) begin
         st_in  = kreyv_load(key, iv);
         rem_in = CW'(WARMUP_ROUNDS);
      end else if (item_pop) begin
         st_in        = stage[sel];
         rsp_data_in  = mixed;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/kreyvium_stream_cipher.sv]
// Top level of the Kreyvium stream cipher: register port, front end and back end.
// Depends on kreyv_pkg, kreyv_front and kreyv_core.
//
// The request channel carries one transaction per item. tuser selects the
// action: low restarts the cipher from the programmed key and IV, high
// encrypts or decrypts the byte in tdata[7:0] with as many keystream bits as
// tdata[11:8] gives (values above eight count as eight), starting at bit 7.
// Each data transaction yields one response transaction holding the byte;
// a restart yields none. The register port writes the key and IV halves and
// is always ready; write it only while no item is pending.
// Eight cipher rounds are unrolled, so a data item is finished as the back
// end pops it; rsp_tvalid rises in the cycle after that pop.
// A restart loads the state and then holds the back end for WARMUP_ROUNDS
// cipher rounds of warm-up.
// A two-entry queue sits between the request side and the cipher; when the
// receiver stalls, the response is held and two more data items fill the
// queue, then req_tready drops. Reset empties the queue and the
// output, clears the cipher state and returns the key to zero and the IV to
// its default pattern.
module kreyvium_stream_cipher import kreyv_pkg::*; #(
   parameter int WARMUP_ROUNDS = WARMUP_ROUNDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_in [7:0], bits_used [11:8], zero [15:12]
   input  logic        req_tuser,   // action [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_out [7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic        item_valid;
   logic        item_pop;
   item_type    item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= KEY_RESET;
         key_low_ff  <= KEY_RESET;
         iv_high_ff  <= IV_RESET;
         iv_low_ff   <= IV_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_IV_HIGH:  iv_high_ff  <= csr_data;
            CSR_IV_LOW:   iv_low_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   kreyv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   kreyv_core #(
      .WARMUP_ROUNDS (WARMUP_ROUNDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .key        ({key_high_ff, key_low_ff}),
      .iv         ({iv_high_ff, iv_low_ff}),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hw/rtl/kreyv_checker.sv]
// Port-level checks for the Kreyvium stream cipher, bound to its top level.
// Depends on kreyvium_stream_cipher.
module kreyv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // Data transactions accepted whose response has not yet been taken.
   logic [3:0] pending_ff, pending_in;
   logic       data_in_acc;
   logic       rsp_acc;

   assign data_in_acc = req_tvalid && req_tready && req_tuser;
   assign rsp_acc     = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (data_in_acc && !rsp_acc) begin
         pending_in = pending_ff + 1'b1;
      end else if (!data_in_acc && rsp_acc) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response valid or request blocked right after reset");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("response without an accepted data transaction");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_bounded_pending: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'd3)
      else $error("more data transactions in flight than queue and output hold");

endmodule

bind kreyvium_stream_cipher kreyv_checker u_checker (.*);

[test/kreyvium_stream_cipher_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for kreyvium_stream_cipher: it sends restart and data transactions,
// predicts every output byte with a bit-level cipher model and checks the bytes in order.
// Depends on kreyv_pkg and the kreyvium_stream_cipher RTL.
module kreyvium_stream_cipher_tb;
   import kreyv_pkg::*;

   localparam int WARMUP        = WARMUP_ROUNDS_DEFAULT;
   // One restart can be warming up in the back end while two more sit in the queue.
   localparam int SETTLE_CYCLES = 3 * (WARMUP / ROUNDS_PER_CYCLE + 8) + 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 47;
   localparam int IDLE_PERCENT  = 37;
   localparam logic [63:0] IV_DEFAULT = 64'h1111_1111_1111_1111;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   // Predictor state: cipher register, rotating key and IV rings, programmed key and IV.
   logic [STATE_BITS-1:0] ks_state;
   logic [KEY_BITS-1:0]   ks_key_ring;
   logic [IV_BITS-1:0]    ks_iv_ring;
   logic [63:0]           csr_shadow [4];
   logic [7:0]            expected_bytes [$];
   logic [7:0]            oldest_byte;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  no_idle = 1'b0;

   kreyvium_stream_cipher #(
      .WARMUP_ROUNDS(WARMUP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // One cipher round; returns the keystream bit and advances the predictor state.
   function automatic logic clock_cipher();
      logic t1, t2, t3, t4, t5, z;
      t4 = ks_key_ring[KEY_BITS-1];
      t5 = ks_iv_ring[IV_BITS-1];
      t1 = ks_state[65] ^ ks_state[92];
      t2 = ks_state[161] ^ ks_state[176];
      t3 = ks_state[242] ^ ks_state[287] ^ t4;
      z  = t1 ^ t2 ^ t3;
      t1 = t1 ^ (ks_state[90] & ks_state[91]) ^ ks_state[170] ^ t5;
      t2 = t2 ^ (ks_state[174] & ks_state[175]) ^ ks_state[263];
      t3 = t3 ^ (ks_state[285] & ks_state[286]) ^ ks_state[68];
      ks_state      = {ks_state[STATE_BITS-2:0], t3};
      ks_state[93]  = t1;
      ks_state[177] = t2;
      ks_key_ring   = {ks_key_ring[KEY_BITS-2:0], t4};
      ks_iv_ring    = {ks_iv_ring[IV_BITS-2:0], t5};
      return z;
   endfunction

   // Key bit i is bit 127-i of {key_high, key_low}; the IV maps the same way.
   task automatic restart_cipher();
      logic [KEY_BITS-1:0] key;
      logic [IV_BITS-1:0]  iv;
      key = {csr_shadow[CSR_KEY_HIGH], csr_shadow[CSR_KEY_LOW]};
      iv  = {csr_shadow[CSR_IV_HIGH], csr_shadow[CSR_IV_LOW]};
      ks_state = '0;
      for (int i = 0; i < 93; i++) ks_state[i] = key[127 - i];
      for (int i = 0; i < 128; i++) ks_state[93 + i] = iv[127 - i];
      for (int i = 221; i < 287; i++) ks_state[i] = 1'b1;
      ks_key_ring = key;
      ks_iv_ring  = iv;
      repeat (WARMUP) void'(clock_cipher());
   endtask

   function automatic logic [7:0] cipher_byte(input logic [7:0] din, input logic [3:0] nbits);
      logic [7:0] dout;
      int         n;
      dout = din;
      n = (nbits > 4'd8) ? 8 : int'(nbits);
      for (int k = 0; k < n; k++) dout[7 - k] = dout[7 - k] ^ clock_cipher();
      return dout;
   endfunction

   // Valid stays high between back-to-back transactions and drops only while idling.
   task automatic send_item(input logic act, input logic [7:0] din, input logic [3:0] nbits);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0000, nbits, din};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACTION_RESTART) restart_cipher();
      else expected_bytes.push_back(cipher_byte(din, nbits));
   endtask

   // Waits for every pending byte, then long enough for queued warm-ups to finish.
   task automatic settle_cipher();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_shadow[idx] = value;
   endtask

   task automatic program_cipher(input logic [63:0] key_hi, key_lo, iv_hi, iv_lo);
      write_csr(CSR_KEY_HIGH, key_hi);
      write_csr(CSR_KEY_LOW, key_lo);
      write_csr(CSR_IV_HIGH, iv_hi);
      write_csr(CSR_IV_LOW, iv_lo);
      csr_valid <= 1'b0;
   endtask

   // The state is all zero after reset, so data passes through the cleared cipher.
   task automatic test_data_before_restart();
      send_item(ACTION_DATA, 8'h00, 4'd8);
      send_item(ACTION_DATA, 8'hFF, 4'd15);
      send_item(ACTION_DATA, 8'hA5, 4'd0);
   endtask

   // Restart on the reset key and IV, then every bit count from none to above eight.
   task automatic test_default_restart();
      send_item(ACTION_RESTART, 8'h00, 4'd0);
      for (int n = 0; n <= 9; n++) send_item(ACTION_DATA, n[0] ? 8'hFF : 8'h00, n[3:0]);
   endtask

   task automatic test_config_extremes();
      logic [63:0] fill;
      for (int pass = 0; pass < 2; pass++) begin
         fill = pass[0] ? 64'h0 : '1;
         settle_cipher();
         program_cipher(fill, fill, fill, fill);
         send_item(ACTION_RESTART, 8'hFF, 4'd15);
         send_item(ACTION_DATA, 8'h00, 4'd8);
         send_item(ACTION_DATA, 8'hFF, 4'd15);
         send_item(ACTION_DATA, 8'h5A, 4'd4);
      end
   endtask

   // Each phase programs a fresh key and IV, restarts, and streams mostly data bytes.
   task automatic test_random_traffic();
      logic [63:0] vals [4];
      int          pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_cipher();
         foreach (vals[r]) begin
            pick = $urandom_range(5);
            vals[r] = (pick == 0) ? 64'h0 : (pick == 1) ? '1 : {$urandom, $urandom};
         end
         program_cipher(vals[0], vals[1], vals[2], vals[3]);
         no_idle = (phase == 4);
         send_item(ACTION_RESTART, 8'($urandom_range(255)), 4'($urandom_range(15)));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            if (pick < 6)
               send_item(ACTION_RESTART, 8'($urandom_range(255)),
                         4'($urandom_range(15)));
            else if (pick < 24)
               send_item(ACTION_DATA, 8'($urandom_range(255)), 4'($urandom_range(15)));
            else
               send_item(ACTION_DATA, 8'($urandom_range(255)), 4'($urandom_range(8, 1)));
         end
      end
      no_idle = 1'b0;
   endtask

   // Response side: random backpressure with occasional long stalls, and the byte check.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %02h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               oldest_byte = expected_bytes.pop_front();
               if (rsp_tdata !== oldest_byte) begin
                  $display("%0t: data_out mismatch, expected %02h, actual %02h",
                           $time, oldest_byte, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (no_idle) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99) == 0) begin
            stall_left = $urandom_range(30, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("kreyvium_stream_cipher regression: fail");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= ACTION_RESTART;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_KEY_HIGH;
      csr_data   <= '0;
      csr_shadow  = '{64'h0, 64'h0, IV_DEFAULT, IV_DEFAULT};
      ks_state    = '0;
      ks_key_ring = '0;
      ks_iv_ring  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_data_before_restart();
      test_default_restart();
      test_config_extremes();
      test_random_traffic();
      settle_cipher();
      if (mismatch_count == 0)
         $display("kreyvium_stream_cipher regression: pass");
      else
         $display("kreyvium_stream_cipher regression: fail");
      $finish;
   end

endmodule

[files.f]
hw/rtl/kreyv_pkg.sv
hw/rtl/kreyv_front.sv
hw/rtl/kreyv_core.sv
hw/rtl/kreyvium_stream_cipher.sv
hw/rtl/kreyv_checker.sv
test/kreyvium_stream_cipher_tb.sv
